FILE: hdl/bta_pkg.sv
package bta_pkg;

	localparam logic [31:0] NO_LINK   = 32'hFFFF_FFFF;
	localparam logic [31:0] FREE_MARK = 32'h8000_0000;
	localparam logic [31:0] SIZE_MASK = 32'h7FFF_FFFF;
	localparam logic [16:0] USED_MAX  = 17'h1_FFFF;

	typedef enum logic [1:0] {
		ST_ALLOC_OK   = 2'd0,
		ST_ALLOC_FAIL = 2'd1,
		ST_RELEASED   = 2'd2,
		ST_REJECTED   = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic {
		CFG_HEAP_START = 1'b0,
		CFG_HEAP_END   = 1'b1
	} cfg_idx_t;

	// write sequences that close out an operation or write the initial tail marker
	typedef enum logic [2:0] {
		WK_INIT,
		WK_A_TAIL,
		WK_A_SPLIT,
		WK_A_EXACT,
		WK_R_TAIL,
		WK_R_FREE
	} wkind_t;

endpackage

FILE: hdl/boundary_tag_heap_allocator.sv
// channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------------------
// in       | in_valid / in_stall   | op, request_bytes, release_address
// out      | out_valid / out_stall | status, block_address, used_bytes, free_bytes
// cfg      | cfg_we                | cfg_index, cfg_data
//
// steps: allocate walks the free list first-fit from its head; release walks the
// free nodes below the block, then merges with free neighbours on both sides.
// reset: a clearing pass zeroes all HEAP_WORDS words of the store, then the tail
// marker is written; a bounds write rewrites the marker before the next item.
// stalls: a finished result waits in the output register; the next item is taken
// meanwhile and holds only at its own end. HEAP_WORDS must be a power of two.
module boundary_tag_heap_allocator #(
	parameter int HEAP_WORDS = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] request_bytes,
	input  logic [15:0] release_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] block_address,
	output logic [16:0] used_bytes,
	output logic [16:0] free_bytes,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(HEAP_WORDS);
	localparam int SW = AW + 2;
	localparam logic [SW-1:0] STEP_LIM = SW'(HEAP_WORDS);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_A_CHK, S_A_RD, S_A_NX, S_A_FIT, S_A_PRV, S_A_NXT,
		S_R_BND, S_R_HDR, S_R_FTR, S_R_CHK, S_R_RD, S_R_NX, S_R_NXT,
		S_R_BEH, S_R_PRE, S_R_PRV, S_R_FWD, S_R_NS, S_R_NN,
		S_WR, S_DONE
	} state_t;

	state_t state_q;

	logic [31:0] tag_store_q [HEAP_WORDS];
	logic [31:0] rdata_q;

	logic [15:0] heap_start_q, heap_end_q;
	logic [16:0] first_free_q, used_q;
	logic        init_pend_q;
	logic [AW-1:0] clr_q;

	logic [31:0] p_q, q_q, sz_q, old_q, prev_q, next_q;
	logic        has_prev_q;
	logic [SW-1:0] steps_q;
	bta_pkg::wkind_t kind_q;
	logic [2:0]  wk_q;
	logic [1:0]  res_status_q;
	logic [15:0] res_addr_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] block_address_q;
	logic [16:0] used_bytes_q, free_bytes_q;

	logic [31:0] he32, hs32, rd_addr, ps, rw_mask;
	logic        rd_neg;
	logic [31:0] slot_addr, slot_data, lnk, pl, nptr, fs;
	logic        slot_we, slot_last;
	logic        mem_we;
	logic [AW-1:0] mem_widx;
	logic [31:0] mem_wdata;
	logic [16:0] sz17, span, freeb;
	logic [17:0] used_sum;

	assign he32   = 32'(heap_end_q);
	assign hs32   = 32'(heap_start_q);
	assign rd_neg = rdata_q[31];
	assign ps     = rdata_q & bta_pkg::SIZE_MASK;
	assign rw_mask = 32'hFFFF_FFF0;
	assign sz17   = (17'(request_bytes) + 17'd23) & rw_mask[16:0];

	assign in_stall  = (state_q != S_IDLE) || init_pend_q || cfg_we;
	assign out_valid = out_valid_q;
	assign status        = status_q;
	assign block_address = block_address_q;
	assign used_bytes    = used_bytes_q;
	assign free_bytes    = free_bytes_q;

	always_comb begin
		unique case (state_q)
			S_A_CHK: rd_addr = p_q;
			S_A_RD:  rd_addr = p_q + 32'd8;
			S_A_FIT: rd_addr = p_q + 32'd4;
			S_A_PRV: rd_addr = p_q + 32'd8;
			S_R_BND: rd_addr = p_q;
			S_R_HDR: rd_addr = p_q + rdata_q - 32'd4;
			S_R_CHK: rd_addr = q_q;
			S_R_RD:  rd_addr = q_q + 32'd8;
			S_R_NXT: rd_addr = prev_q + 32'd8;
			S_R_BEH: rd_addr = p_q - 32'd4;
			S_R_PRE: rd_addr = p_q - ps + 32'd4;
			S_R_FWD: rd_addr = p_q + sz_q;
			S_R_NS:  rd_addr = p_q + sz_q + 32'd8;
			default: rd_addr = 32'd0;
		endcase
	end

	// one write per cycle, in the order the block layout needs
	always_comb begin
		nptr = p_q + sz_q;
		fs   = old_q - sz_q;
		pl   = has_prev_q ? prev_q : bta_pkg::NO_LINK;
		case (kind_q)
			bta_pkg::WK_A_EXACT: lnk = next_q;
			bta_pkg::WK_R_TAIL, bta_pkg::WK_R_FREE: lnk = p_q;
			default: lnk = nptr;
		endcase
		slot_we   = 1'b1;
		slot_last = 1'b0;
		slot_addr = 32'd0;
		slot_data = 32'd0;
		unique case (kind_q)
			bta_pkg::WK_INIT: begin
				case (wk_q)
					3'd0: begin slot_addr = hs32; slot_data = 32'd0; end
					default: begin
						slot_addr = hs32 + 32'd4; slot_data = bta_pkg::NO_LINK; slot_last = 1'b1;
					end
				endcase
			end
			bta_pkg::WK_A_TAIL: begin
				case (wk_q)
					3'd0: begin slot_addr = nptr; slot_data = 32'd0; end
					3'd1: begin slot_addr = nptr + 32'd4; slot_data = prev_q; end
					3'd2: begin slot_addr = p_q; slot_data = sz_q; end
					3'd3: begin slot_addr = nptr - 32'd4; slot_data = sz_q; end
					default: begin
						slot_addr = prev_q + 32'd8; slot_data = lnk;
						slot_we = has_prev_q; slot_last = 1'b1;
					end
				endcase
			end
			bta_pkg::WK_A_SPLIT: begin
				case (wk_q)
					3'd0: begin slot_addr = nptr; slot_data = fs | bta_pkg::FREE_MARK; end
					3'd1: begin
						slot_addr = p_q + old_q - 32'd4; slot_data = fs | bta_pkg::FREE_MARK;
					end
					3'd2: begin slot_addr = nptr + 32'd4; slot_data = prev_q; end
					3'd3: begin slot_addr = nptr + 32'd8; slot_data = next_q; end
					3'd4: begin slot_addr = next_q + 32'd4; slot_data = nptr; end
					3'd5: begin slot_addr = p_q; slot_data = sz_q; end
					3'd6: begin slot_addr = nptr - 32'd4; slot_data = sz_q; end
					default: begin
						slot_addr = prev_q + 32'd8; slot_data = lnk;
						slot_we = has_prev_q; slot_last = 1'b1;
					end
				endcase
			end
			bta_pkg::WK_A_EXACT: begin
				case (wk_q)
					3'd0: begin slot_addr = next_q + 32'd4; slot_data = prev_q; end
					3'd1: begin slot_addr = p_q; slot_data = sz_q; end
					3'd2: begin slot_addr = nptr - 32'd4; slot_data = sz_q; end
					default: begin
						slot_addr = prev_q + 32'd8; slot_data = lnk;
						slot_we = has_prev_q; slot_last = 1'b1;
					end
				endcase
			end
			bta_pkg::WK_R_TAIL: begin
				case (wk_q)
					3'd0: begin slot_addr = p_q; slot_data = 32'd0; end
					3'd1: begin slot_addr = p_q + 32'd4; slot_data = pl; end
					default: begin
						slot_addr = prev_q + 32'd8; slot_data = lnk;
						slot_we = has_prev_q; slot_last = 1'b1;
					end
				endcase
			end
			default: begin
				case (wk_q)
					3'd0: begin slot_addr = p_q; slot_data = sz_q | bta_pkg::FREE_MARK; end
					3'd1: begin
						slot_addr = nptr - 32'd4; slot_data = sz_q | bta_pkg::FREE_MARK;
					end
					3'd2: begin slot_addr = p_q + 32'd4; slot_data = pl; end
					3'd3: begin slot_addr = p_q + 32'd8; slot_data = next_q; end
					3'd4: begin slot_addr = next_q + 32'd4; slot_data = p_q; end
					default: begin
						slot_addr = prev_q + 32'd8; slot_data = lnk;
						slot_we = has_prev_q; slot_last = 1'b1;
					end
				endcase
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_widx  = slot_addr[AW+1:2];
		mem_wdata = slot_data;
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_widx  = clr_q;
			mem_wdata = 32'd0;
		end else if (state_q == S_WR) begin
			mem_we = slot_we;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_store_q[mem_widx] <= mem_wdata;
		end
		rdata_q <= tag_store_q[rd_addr[AW+1:2]];
	end

	assign used_sum = 18'(used_q) + 18'(sz_q[16:0]);
	assign span  = (heap_end_q >= heap_start_q) ? 17'(heap_end_q - heap_start_q) : 17'd0;
	assign freeb = (span > used_q) ? span - used_q : 17'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLR;
			clr_q           <= '0;
			heap_start_q    <= 16'd0;
			heap_end_q      <= 16'hFFFF;
			first_free_q    <= 17'd0;
			used_q          <= 17'd0;
			init_pend_q     <= 1'b1;
			p_q             <= 32'd0;
			q_q             <= 32'd0;
			sz_q            <= 32'd0;
			old_q           <= 32'd0;
			prev_q          <= 32'd0;
			next_q          <= 32'd0;
			has_prev_q      <= 1'b0;
			steps_q         <= '0;
			kind_q          <= bta_pkg::WK_INIT;
			wk_q            <= 3'd0;
			res_status_q    <= 2'd0;
			res_addr_q      <= 16'd0;
			out_valid_q     <= 1'b0;
			status_q        <= 2'd0;
			block_address_q <= 16'd0;
			used_bytes_q    <= 17'd0;
			free_bytes_q    <= 17'd0;
		end else begin
			// a result leaving while the next one is ready is handled in S_DONE
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (init_pend_q) begin
						kind_q  <= bta_pkg::WK_INIT;
						wk_q    <= 3'd0;
						state_q <= S_WR;
					end else if (in_valid && !cfg_we) begin
						steps_q <= '0;
						if (op == bta_pkg::OP_ALLOC) begin
							sz_q    <= 32'(sz17);
							p_q     <= 32'(first_free_q);
							state_q <= S_A_CHK;
						end else begin
							p_q     <= 32'(release_address) - 32'd4;
							state_q <= S_R_BND;
						end
					end
				end
				// first-fit walk
				S_A_CHK: begin
					if (p_q <= he32 && steps_q <= STEP_LIM) begin
						state_q <= S_A_RD;
					end else begin
						res_status_q <= bta_pkg::ST_ALLOC_FAIL;
						state_q      <= S_DONE;
					end
				end
				S_A_RD: begin
					steps_q <= steps_q + 1'b1;
					old_q   <= ps;
					if (rdata_q == 32'd0 || (rd_neg && sz_q <= ps)) begin
						state_q <= S_A_FIT;
					end else if (!rd_neg) begin
						res_status_q <= bta_pkg::ST_ALLOC_FAIL;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_A_NX;
					end
				end
				S_A_NX: begin
					p_q     <= rdata_q;
					state_q <= S_A_CHK;
				end
				S_A_FIT: begin
					if (p_q + sz_q > he32) begin
						res_status_q <= bta_pkg::ST_ALLOC_FAIL;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_A_PRV;
					end
				end
				S_A_PRV: begin
					prev_q     <= rdata_q;
					has_prev_q <= (rdata_q != bta_pkg::NO_LINK);
					state_q    <= S_A_NXT;
				end
				S_A_NXT: begin
					next_q <= rdata_q;
					wk_q   <= 3'd0;
					if (old_q == 32'd0) begin
						kind_q <= bta_pkg::WK_A_TAIL;
					end else if (sz_q < old_q) begin
						kind_q <= bta_pkg::WK_A_SPLIT;
					end else begin
						kind_q <= bta_pkg::WK_A_EXACT;
					end
					state_q <= S_WR;
				end
				// release checks
				S_R_BND: begin
					if (p_q < hs32 || p_q > he32) begin
						res_status_q <= bta_pkg::ST_REJECTED;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_R_HDR;
					end
				end
				S_R_HDR: begin
					sz_q <= rdata_q;
					if (rd_neg || rdata_q < 32'd16 || rdata_q[3:0] != 4'd0 ||
					    p_q + rdata_q > he32) begin
						res_status_q <= bta_pkg::ST_REJECTED;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_R_FTR;
					end
				end
				S_R_FTR: begin
					has_prev_q <= 1'b0;
					prev_q     <= 32'd0;
					q_q        <= 32'(first_free_q);
					if (rdata_q != sz_q) begin
						res_status_q <= bta_pkg::ST_REJECTED;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_R_CHK;
					end
				end
				S_R_CHK: begin
					if (q_q > p_q) begin
						used_q  <= (32'(used_q) > sz_q) ? used_q - sz_q[16:0] : 17'd0;
						state_q <= S_R_NXT;
					end else if (steps_q > STEP_LIM) begin
						res_status_q <= bta_pkg::ST_REJECTED;
						state_q      <= S_DONE;
					end else begin
						steps_q <= steps_q + 1'b1;
						state_q <= S_R_RD;
					end
				end
				S_R_RD: begin
					if (!rd_neg) begin
						res_status_q <= bta_pkg::ST_REJECTED;
						state_q      <= S_DONE;
					end else begin
						has_prev_q <= 1'b1;
						prev_q     <= q_q;
						state_q    <= S_R_NX;
					end
				end
				S_R_NX: begin
					q_q     <= rdata_q;
					state_q <= S_R_CHK;
				end
				S_R_NXT: begin
					state_q <= S_R_BEH;
				end
				S_R_BEH: begin
					next_q  <= has_prev_q ? rdata_q : 32'(first_free_q);
					state_q <= (p_q > hs32) ? S_R_PRE : S_R_FWD;
				end
				// merge with a free block just below
				S_R_PRE: begin
					if (rd_neg) begin
						p_q     <= p_q - ps;
						sz_q    <= sz_q + ps;
						state_q <= S_R_PRV;
					end else begin
						state_q <= S_R_FWD;
					end
				end
				S_R_PRV: begin
					prev_q     <= rdata_q;
					has_prev_q <= (rdata_q != bta_pkg::NO_LINK);
					state_q    <= S_R_FWD;
				end
				S_R_FWD: begin
					state_q <= S_R_NS;
				end
				S_R_NS: begin
					wk_q <= 3'd0;
					if (rd_neg) begin
						sz_q    <= sz_q + ps;
						kind_q  <= bta_pkg::WK_R_FREE;
						state_q <= S_R_NN;
					end else begin
						kind_q  <= (rdata_q == 32'd0) ? bta_pkg::WK_R_TAIL : bta_pkg::WK_R_FREE;
						state_q <= S_WR;
					end
				end
				S_R_NN: begin
					next_q  <= rdata_q;
					state_q <= S_WR;
				end
				S_WR: begin
					wk_q <= wk_q + 3'd1;
					if (slot_last) begin
						if (kind_q == bta_pkg::WK_INIT) begin
							init_pend_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							if (!has_prev_q) begin
								first_free_q <= lnk[16:0];
							end
							if (kind_q == bta_pkg::WK_R_TAIL || kind_q == bta_pkg::WK_R_FREE) begin
								res_status_q <= bta_pkg::ST_RELEASED;
							end else begin
								res_status_q <= bta_pkg::ST_ALLOC_OK;
								res_addr_q   <= p_q[15:0] + 16'd4;
								used_q       <= used_sum[17] ? bta_pkg::USED_MAX : used_sum[16:0];
							end
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						status_q        <= res_status_q;
						block_address_q <= (res_status_q == bta_pkg::ST_ALLOC_OK) ? res_addr_q : 16'd0;
						used_bytes_q    <= used_q;
						free_bytes_q    <= freeb;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// bounds write restarts the heap
			if (cfg_we) begin
				if (cfg_index == bta_pkg::CFG_HEAP_START) begin
					heap_start_q <= cfg_data;
					first_free_q <= 17'(cfg_data);
				end else begin
					heap_end_q   <= cfg_data;
					first_free_q <= 17'(heap_start_q);
				end
				used_q      <= 17'd0;
				init_pend_q <= 1'b1;
			end
		end
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> state_q == S_IDLE && !init_pend_q)
		else $error("item taken while busy");
	a_alloc_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bta_pkg::ST_ALLOC_OK |-> used_bytes >= 17'd16)
		else $error("allocation without used bytes");
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bta_pkg::ST_ALLOC_OK |-> block_address == 16'd0)
		else $error("address on non-allocation");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STEP_LIM + 1'b1)
		else $error("walk step count overrun");
	a_clr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> in_stall && !out_valid_q)
		else $error("activity during clearing pass");

endmodule

FILE: sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HW = 16384;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		bta_pkg::status_t status;
		logic [15:0] addr;
		logic [16:0] used;
		logic [16:0] freeb;
	} heap_result_t;

	// in-order predictor of the allocator plus the queue of results still owed
	class heap_scoreboard;
		logic [31:0]  tags [HW];
		logic [31:0]  first_free, used_total, hstart, hend;
		heap_result_t owed[$];
		int           errors;

		function logic [31:0] rd(logic [31:0] a);
			return tags[(a >> 2) & (HW - 1)];
		endfunction

		function void wr(logic [31:0] a, logic [31:0] v);
			tags[(a >> 2) & (HW - 1)] = v;
		endfunction

		function void put_used(logic [31:0] p, logic [31:0] sz);
			wr(p, sz);
			wr(p + sz - 4, sz);
		endfunction

		function void put_free(logic [31:0] p, logic [31:0] sz, logic [31:0] pv,
				logic [31:0] nx);
			wr(p, sz | bta_pkg::FREE_MARK);
			wr(p + sz - 4, sz | bta_pkg::FREE_MARK);
			wr(p + 4, pv);
			wr(p + 8, nx);
		endfunction

		function void put_tail(logic [31:0] p, logic [31:0] pv);
			wr(p, 0);
			wr(p + 4, pv);
		endfunction

		function void link_after(bit has_prev, logic [31:0] pv, logic [31:0] nx);
			if (!has_prev) first_free = nx & 32'h1_FFFF;
			else wr(pv + 8, nx);
		endfunction

		function void init_heap();
			first_free = hstart;
			used_total = 0;
			put_tail(hstart, bta_pkg::NO_LINK);
		endfunction

		function void clear();
			foreach (tags[i]) tags[i] = 0;
			hstart = 0;
			hend = 65535;
			errors = 0;
			init_heap();
		endfunction

		function void write_bound(bta_pkg::cfg_idx_t idx, logic [15:0] v);
			if (idx == bta_pkg::CFG_HEAP_START) hstart = v;
			else hend = v;
			init_heap();
		endfunction

		function bit carve(logic [31:0] req, output logic [31:0] addr);
			logic [31:0] sz, p, steps, w, old, pv, nptr, nx, hn;
			bit found;
			sz = (req + 23) & 32'hFFFF_FFF0;
			p = first_free;
			steps = 0;
			found = 0;
			addr = 0;
			while (p <= hend && steps <= HW) begin
				w = rd(p);
				steps++;
				if (w == 0) begin
					found = 1;
					break;
				end
				if (!w[31]) break;
				if (sz <= (w & bta_pkg::SIZE_MASK)) begin
					found = 1;
					break;
				end
				p = rd(p + 8);
			end
			if (!found || p + sz > hend) return 0;
			old = rd(p) & bta_pkg::SIZE_MASK;
			pv = rd(p + 4);
			nptr = p + sz;
			nx = nptr;
			if (old == 0) begin
				put_tail(nptr, pv);
			end else if (sz < old) begin
				hn = rd(p + 8);
				put_free(nptr, old - sz, pv, hn);
				wr(hn + 4, nptr);
			end else begin
				nx = rd(p + 8);
				wr(nx + 4, pv);
			end
			put_used(p, sz);
			link_after(pv != bta_pkg::NO_LINK, pv, nx);
			used_total += sz;
			if (used_total > 32'h1_FFFF) used_total = 32'h1_FFFF;
			addr = p + 4;
			return 1;
		endfunction

		function bit give_back(logic [31:0] a);
			logic [31:0] p, s1, pv, q, steps, sz, nx, ps, nptr, ns, pl;
			bit has_prev;
			p = a - 4;
			if (p < hstart || p > hend) return 0;
			s1 = rd(p);
			if (s1[31] || s1 < 16 || s1[3:0] != 0 || p + s1 > hend) return 0;
			if (rd(p + s1 - 4) != s1) return 0;
			has_prev = 0;
			pv = 0;
			q = first_free;
			steps = 0;
			while (q <= p) begin
				if (steps > HW) return 0;
				steps++;
				ps = rd(q);
				if (!ps[31]) return 0;
				has_prev = 1;
				pv = q;
				q = rd(q + 8);
			end
			used_total = (used_total > s1) ? used_total - s1 : 0;
			sz = s1;
			nx = has_prev ? rd(pv + 8) : first_free;
			if (p > hstart) begin
				ps = rd(p - 4);
				if (ps[31]) begin
					ps &= bta_pkg::SIZE_MASK;
					p -= ps;
					sz += ps;
					pv = rd(p + 4);
					has_prev = (pv != bta_pkg::NO_LINK);
				end
			end
			nptr = p + sz;
			ns = rd(nptr);
			if (ns[31]) begin
				sz += ns & bta_pkg::SIZE_MASK;
				nx = rd(nptr + 8);
			end
			pl = has_prev ? pv : bta_pkg::NO_LINK;
			if (ns == 0) begin
				put_tail(p, pl);
			end else begin
				put_free(p, sz, pl, nx);
				wr(nx + 4, p);
			end
			link_after(has_prev, pv, p);
			return 1;
		endfunction

		function heap_result_t note_request(bta_pkg::op_t o, logic [15:0] rq,
				logic [15:0] rl);
			heap_result_t r;
			logic [31:0] a, span;
			a = 0;
			if (o == bta_pkg::OP_ALLOC)
				r.status = carve({16'h0, rq}, a) ? bta_pkg::ST_ALLOC_OK : bta_pkg::ST_ALLOC_FAIL;
			else
				r.status = give_back({16'h0, rl}) ? bta_pkg::ST_RELEASED : bta_pkg::ST_REJECTED;
			if (r.status != bta_pkg::ST_ALLOC_OK) a = 0;
			span = (hend >= hstart) ? hend - hstart : 0;
			r.addr = a[15:0];
			r.used = used_total[16:0];
			r.freeb = (span > used_total) ? 17'(span - used_total) : 17'd0;
			owed.push_back(r);
			return r;
		endfunction

		function void check_result(logic [1:0] st, logic [15:0] ad, logic [16:0] ub,
				logic [16:0] fb);
			heap_result_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result status=%0d addr=%h", $time, st, ad);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (ad !== e.addr) begin
				$display("%0t: block_address expected %h actual %h", $time, e.addr, ad);
				errors++;
			end
			if (ub !== e.used) begin
				$display("%0t: used_bytes expected %0d actual %0d", $time, e.used, ub);
				errors++;
			end
			if (fb !== e.freeb) begin
				$display("%0t: free_bytes expected %0d actual %0d", $time, e.freeb, fb);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        op = 0;
	logic [15:0] request_bytes = 0;
	logic [15:0] release_address = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status;
	logic [15:0] block_address;
	logic [16:0] used_bytes;
	logic [16:0] free_bytes;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [15:0] cfg_data = 0;

	heap_scoreboard sb = new();
	int  send_idle = 0;
	int  recv_idle = 0;
	bit  hold_req = 0;
	int  cycles = 0;
	logic [15:0] live[$];
	logic [15:0] freed[$];

	boundary_tag_heap_allocator u_dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (out_valid && !out_stall)
			sb.check_result(status, block_address, used_bytes, free_bytes);

	// long hold-off counted here so the block backs up into its input
	int  hold_left = 0;
	bit  hold_done = 0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_stall <= 1;
			hold_left <= 500;
			hold_done <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic send_request(bta_pkg::op_t o, logic [15:0] rq, logic [15:0] rl);
		heap_result_t r;
		int k;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		op <= o;
		request_bytes <= rq;
		release_address <= rl;
		do @(posedge clk); while (in_stall);
		r = sb.note_request(o, rq, rl);
		if (r.status == bta_pkg::ST_ALLOC_OK) live.push_back(r.addr);
		if (r.status == bta_pkg::ST_RELEASED) begin
			for (k = 0; k < live.size(); k++)
				if (live[k] == rl) begin
					live.delete(k);
					break;
				end
			freed.push_back(rl);
			if (freed.size() > 8) void'(freed.pop_front());
		end
	endtask

	task automatic alloc(logic [15:0] rq);
		send_request(bta_pkg::OP_ALLOC, rq, 16'($urandom));
	endtask

	task automatic release_at(logic [15:0] rl);
		send_request(bta_pkg::OP_RELEASE, 16'($urandom), rl);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_bounds(logic [15:0] s, logic [15:0] e);
		drain();
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= bta_pkg::CFG_HEAP_START;
		cfg_data <= s;
		@(negedge clk);
		cfg_index <= bta_pkg::CFG_HEAP_END;
		cfg_data <= e;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_bound(bta_pkg::CFG_HEAP_START, s);
		sb.write_bound(bta_pkg::CFG_HEAP_END, e);
		live.delete();
		freed.delete();
	endtask

	task automatic random_items(int n);
		int  pick;
		logic [15:0] rq;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 55 || live.size() == 0) begin
				if (pick % 10 == 0) rq = 16'($urandom_range(2000));
				else if (pick == 3) rq = 16'($urandom);
				else rq = 16'($urandom_range(120));
				alloc(rq);
			end else if (pick < 90) begin
				release_at(live[$urandom_range(live.size() - 1)]);
			end else if (pick < 95 && freed.size() != 0) begin
				release_at(freed[$urandom_range(freed.size() - 1)]);
			end else begin
				release_at(16'($urandom));
			end
		end
	endtask

	initial begin
		logic [15:0] a, b, c;
		sb.clear();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: extremes, block at zero, bad releases, merges on both sides
		alloc(0);
		release_at(16'd4);
		release_at(16'd4);
		release_at(16'd0);
		release_at(16'd2);
		alloc(16'hFFFF);
		alloc(16'd1);
		alloc(16'd8);
		alloc(16'd40);
		a = live[0];
		b = live[1];
		c = live[2];
		alloc(16'd24);
		release_at(a);
		release_at(c);
		release_at(b);
		alloc(16'd8);
		release_at(16'hFFFF);
		release_at(16'h8000);
		alloc(16'd60000);
		alloc(16'd100);

		send_idle = 25;
		recv_idle = 53;
		random_items(380);

		set_bounds(16'h0104, 16'h3000);
		send_idle = 53;
		recv_idle = 25;
		random_items(100);
		hold_req = 1;
		random_items(200);

		set_bounds(16'hFFFF, 16'hFFFF);
		alloc(0);
		release_at(16'h0003);
		set_bounds(16'h2000, 16'h1000);
		alloc(16'd1);
		release_at(16'h1004);
		set_bounds(16'h0000, 16'h0000);
		alloc(0);
		alloc(16'hFFFF);

		set_bounds(16'h0000, 16'hFFFF);
		send_idle = 0;
		recv_idle = 0;
		random_items(350);

		drain();
		if (sb.errors == 0 && sb.owed.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
